@@ src/gkp_pkg.sv @@
// Shared types and constants of the Gabor kernel point evaluator.
// No dependencies; used by every module in src.
`default_nettype none
package gkp_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned ITERATIONS_DEF = 16;

  localparam logic signed [31:0] TWO_PI_Q28    = 32'sd1686629713;
  localparam logic [64:0]        EXP_LIMIT_Q36 = 65'd12 << 36;

  localparam logic [2:0] REG_COS   = 3'd0;
  localparam logic [2:0] REG_SIN   = 3'd1;
  localparam logic [2:0] REG_GX    = 3'd2;
  localparam logic [2:0] REG_GY    = 3'd3;
  localparam logic [2:0] REG_FREQ  = 3'd4;
  localparam logic [2:0] REG_PHASE = 3'd5;

  localparam logic signed [15:0] COS_RST   = 16'sd16384;
  localparam logic signed [15:0] SIN_RST   = 16'sd0;
  localparam logic [23:0]        GX_RST    = 24'd204800;
  localparam logic [23:0]        GY_RST    = 24'd51200;
  localparam logic [19:0]        FREQ_RST  = 20'd13038;
  localparam logic [15:0]        PHASE_RST = 16'd0;

  // sideband that travels with every pipeline stage
  typedef struct packed {
    logic valid;
    logic last;
    logic under;
  } gkp_side_t;

endpackage
`default_nettype wire

@@ src/gabor_kernel_point.sv @@
// Top level: register file, rotation, envelope and squaring pipeline, output.
// Depends on gkp_pkg, gkp_rotate, gkp_gauss, gkp_square.
//
//  channel   signals                               direction
//  request   start_i, pos_x_i, pos_y_i, last_point_i  in (busy_o always low)
//  result    kernel_valid_o, kernel_value_o, last_out_o out (one-cycle strobe)
//  config    psel penable pwrite paddr pwdata            in; prdata pready out
//
// One request per cycle; the path runs through the rotation, the envelope, the
// chain of ITERATIONS complex squarings, two stages each, and the output register.
// Reset clears valid bits and loads the register reset values.
// Nothing stalls: busy_o stays low and results leave on a strobe.
`default_nettype none
module gabor_kernel_point #(
  parameter int unsigned COORD_BITS = gkp_pkg::COORD_BITS_DEF,
  parameter int unsigned ITERATIONS = gkp_pkg::ITERATIONS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  output logic                           busy_o,
  input  wire logic signed [COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [COORD_BITS-1:0] pos_y_i,
  input  wire                            last_point_i,
  output logic                           kernel_valid_o,
  output logic signed [15:0]             kernel_value_o,
  output logic                           last_out_o,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire logic [4:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  localparam int unsigned LAT = 2 * ITERATIONS + 7;

  logic signed [15:0] cos_q, sin_q;
  logic [23:0]        gx_q, gy_q;
  logic [19:0]        freq_q;
  logic [15:0]        phase_q;
  logic               wr_en;
  logic               accept;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign wr_en  = psel && penable && pwrite;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= gkp_pkg::COS_RST;
      sin_q   <= gkp_pkg::SIN_RST;
      gx_q    <= gkp_pkg::GX_RST;
      gy_q    <= gkp_pkg::GY_RST;
      freq_q  <= gkp_pkg::FREQ_RST;
      phase_q <= gkp_pkg::PHASE_RST;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        gkp_pkg::REG_COS:   cos_q   <= pwdata[15:0];
        gkp_pkg::REG_SIN:   sin_q   <= pwdata[15:0];
        gkp_pkg::REG_GX:    gx_q    <= pwdata[23:0];
        gkp_pkg::REG_GY:    gy_q    <= pwdata[23:0];
        gkp_pkg::REG_FREQ:  freq_q  <= pwdata[19:0];
        gkp_pkg::REG_PHASE: phase_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      gkp_pkg::REG_COS:   prdata = 32'({16'h0, cos_q});
      gkp_pkg::REG_SIN:   prdata = 32'({16'h0, sin_q});
      gkp_pkg::REG_GX:    prdata = 32'(gx_q);
      gkp_pkg::REG_GY:    prdata = 32'(gy_q);
      gkp_pkg::REG_FREQ:  prdata = 32'(freq_q);
      gkp_pkg::REG_PHASE: prdata = 32'(phase_q);
      default:            prdata = 32'h0;
    endcase
  end

  gkp_pkg::gkp_side_t          side_in, side_rot, side_g;
  logic signed [COORD_BITS+3:0] xr, yr;
  logic signed [31:0]          re_g, im_g;

  assign side_in = '{valid: accept, last: last_point_i, under: 1'b0};

  gkp_rotate #(.COORD_BITS(COORD_BITS)) u_rotate (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .x_i (pos_x_i), .y_i (pos_y_i), .cos_i (cos_q), .sin_i (sin_q),
    .side_i (side_in), .xr_o (xr), .yr_o (yr), .side_o (side_rot)
  );

  gkp_gauss #(.COORD_BITS(COORD_BITS), .ITERATIONS(ITERATIONS)) u_gauss (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .xr_i (xr), .yr_i (yr), .side_i (side_rot),
    .gx_i (gx_q), .gy_i (gy_q), .freq_i (freq_q), .phase_i (phase_q),
    .re_o (re_g), .im_o (im_g), .side_o (side_g)
  );

  logic signed [31:0]  re_c   [ITERATIONS+1];
  logic signed [31:0]  im_c   [ITERATIONS+1];
  gkp_pkg::gkp_side_t  side_c [ITERATIONS+1];

  assign re_c[0]   = re_g;
  assign im_c[0]   = im_g;
  assign side_c[0] = side_g;

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_sq
    gkp_square u_square (
      .clk_i (clk_i), .rst_ni (rst_ni),
      .re_i (re_c[k]), .im_i (im_c[k]), .side_i (side_c[k]),
      .re_o (re_c[k+1]), .im_o (im_c[k+1]), .side_o (side_c[k+1])
    );
  end

  logic signed [32:0] vr;
  logic signed [32:0] v;
  logic signed [15:0] kv_d;
  gkp_pkg::gkp_side_t sf;

  assign sf = side_c[ITERATIONS];
  assign vr = 33'(re_c[ITERATIONS]) + 33'sd16384;
  assign v  = vr >>> 15;

  always_comb begin
    priority if (sf.under)     kv_d = 16'sd0;
    else if (v > 33'sd32767)   kv_d = 16'sd32767;
    else if (v < -33'sd32768)  kv_d = -16'sd32768;
    else                       kv_d = 16'(v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_valid_o <= 1'b0;
    end else begin
      kernel_valid_o <= sf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    kernel_value_o <= kv_d;
    last_out_o     <= sf.last;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT kernel_valid_o)
    else $error("request produced no result at the pipeline latency");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    kernel_valid_o |-> $past(accept, LAT))
    else $error("result without a matching request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sf.valid && sf.under |=> kernel_valid_o && kernel_value_o == 16'sd0)
    else $error("underflowed point gave a nonzero value");
endmodule
`default_nettype wire

@@ src/gkp_rotate.sv @@
// Two-stage rotation of the request coordinates by the orientation.
// Depends on gkp_pkg.
`default_nettype none
module gkp_rotate #(
  parameter int unsigned COORD_BITS = gkp_pkg::COORD_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire logic signed [COORD_BITS-1:0] x_i,
  input  wire logic signed [COORD_BITS-1:0] y_i,
  input  wire logic signed [15:0]        cos_i,
  input  wire logic signed [15:0]        sin_i,
  input  wire gkp_pkg::gkp_side_t        side_i,
  output logic signed [COORD_BITS+3:0]   xr_o,
  output logic signed [COORD_BITS+3:0]   yr_o,
  output gkp_pkg::gkp_side_t             side_o
);
  localparam int unsigned PW = COORD_BITS + 16;
  localparam int unsigned SW = COORD_BITS + 18;
  localparam logic signed [SW-1:0] HALF = SW'(1) << 13;

  logic signed [PW-1:0] xc_q, ys_q, yc_q, xs_q;
  gkp_pkg::gkp_side_t   s1_q;
  logic signed [SW-1:0] sx, sy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      side_o <= '0;
    end else begin
      s1_q   <= side_i;
      side_o <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xc_q <= PW'(x_i) * PW'(cos_i);
    ys_q <= PW'(y_i) * PW'(sin_i);
    yc_q <= PW'(y_i) * PW'(cos_i);
    xs_q <= PW'(x_i) * PW'(sin_i);
  end

  assign sx = SW'(xc_q) + SW'(ys_q) + HALF;
  assign sy = SW'(yc_q) - SW'(xs_q) + HALF;

  always_ff @(posedge clk_i) begin
    xr_o <= sx[SW-1:14];
    yr_o <= sy[SW-1:14];
  end
endmodule
`default_nettype wire

@@ src/gkp_gauss.sv @@
// Envelope argument, underflow test, phase angle and the starting point z
// of the repeated squaring; four register stages. Depends on gkp_pkg.
`default_nettype none
module gkp_gauss #(
  parameter int unsigned COORD_BITS = gkp_pkg::COORD_BITS_DEF,
  parameter int unsigned ITERATIONS = gkp_pkg::ITERATIONS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire logic signed [COORD_BITS+3:0] xr_i,
  input  wire logic signed [COORD_BITS+3:0] yr_i,
  input  wire gkp_pkg::gkp_side_t        side_i,
  input  wire logic [23:0]               gx_i,
  input  wire logic [23:0]               gy_i,
  input  wire logic [19:0]               freq_i,
  input  wire logic [15:0]               phase_i,
  output logic signed [31:0]             re_o,
  output logic signed [31:0]             im_o,
  output gkp_pkg::gkp_side_t             side_o
);
  localparam int unsigned RW  = COORD_BITS + 4;
  localparam int unsigned AXW = (RW > 21) ? RW : 21;
  localparam int unsigned XW  = (RW > 24) ? RW : 24;

  gkp_pkg::gkp_side_t s1_q, s2_q, s3_q;

  // stage 1: magnitudes squared, frequency product
  logic [RW-1:0]         ax, ay;
  logic [AXW-1:0]        axe, aye;
  logic signed [XW-1:0]  xre;
  logic [43:0]           tpf;
  logic [39:0]           sqx_q, sqy_q;
  logic                  bigx_q, bigy_q;
  logic [23:0]           tp_q;

  assign ax  = xr_i[RW-1] ? RW'(-xr_i) : RW'(xr_i);
  assign ay  = yr_i[RW-1] ? RW'(-yr_i) : RW'(yr_i);
  assign axe = AXW'(ax);
  assign aye = AXW'(ay);
  assign xre = XW'(xr_i);
  assign tpf = 44'(freq_i) * 44'(xre[23:0]);

  always_ff @(posedge clk_i) begin
    sqx_q  <= 40'(axe[19:0]) * 40'(axe[19:0]);
    sqy_q  <= 40'(aye[19:0]) * 40'(aye[19:0]);
    bigx_q <= |axe[AXW-1:20];
    bigy_q <= |aye[AXW-1:20];
    tp_q   <= tpf[23:0];
  end

  // stage 2: weighted terms, wrapped angle in turns
  logic [39:0]        sqcx, sqcy;
  logic [23:0]        tl;
  logic [63:0]        px_q, py_q;
  logic signed [15:0] turns_q;

  assign sqcx = bigx_q ? '1 : sqx_q;
  assign sqcy = bigy_q ? '1 : sqy_q;
  assign tl   = tp_q + 24'd128;

  always_ff @(posedge clk_i) begin
    px_q    <= 64'(sqcx) * 64'(gx_i);
    py_q    <= 64'(sqcy) * 64'(gy_i);
    turns_q <= tl[23:8] - phase_i;
  end

  // stage 3: argument sum, underflow, angle scaled by two pi
  logic [64:0]        asum;
  logic [39:0]        a_q;
  logic signed [47:0] ip_q;
  logic               under_q;

  assign asum = 65'(px_q) + 65'(py_q);

  always_ff @(posedge clk_i) begin
    a_q     <= asum[39:0];
    under_q <= asum >= gkp_pkg::EXP_LIMIT_Q36;
    ip_q    <= 48'(turns_q) * 48'(gkp_pkg::TWO_PI_Q28);
  end

  // stage 4: z = 1 + (-a + i*theta) / 2^ITERATIONS
  logic [40:0]        ar;
  logic [40:0]        ash;
  logic signed [47:0] ipr;

  assign ar  = 41'(a_q) + (41'(1) << (5 + ITERATIONS));
  assign ash = ar >> (6 + ITERATIONS);
  assign ipr = ip_q + (48'sd1 <<< (13 + ITERATIONS));

  always_ff @(posedge clk_i) begin
    re_o <= (32'sd1 <<< 30) - 32'(ash);
    im_o <= 32'(ipr >>> (14 + ITERATIONS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      s3_q   <= '0;
      side_o <= '0;
    end else begin
      s1_q   <= side_i;
      s2_q   <= s1_q;
      s3_q   <= '{valid: s2_q.valid, last: s2_q.last,
                  under: asum >= gkp_pkg::EXP_LIMIT_Q36};
      side_o <= s3_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_q.valid |-> (s3_q.under == under_q))
    else $error("underflow flag lost its item");
endmodule
`default_nettype wire

@@ src/gkp_square.sv @@
// One complex squaring of z in Q2.30: a multiply stage and a rounding stage.
// Depends on gkp_pkg.
`default_nettype none
module gkp_square (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire logic signed [31:0] re_i,
  input  wire logic signed [31:0] im_i,
  input  wire gkp_pkg::gkp_side_t side_i,
  output logic signed [31:0]      re_o,
  output logic signed [31:0]      im_o,
  output gkp_pkg::gkp_side_t      side_o
);
  localparam logic signed [65:0] HALF = 66'sd1 <<< 29;

  logic signed [63:0] rr_q, ii_q, ri_q;
  gkp_pkg::gkp_side_t s1_q;
  logic signed [65:0] dr, di;

  always_ff @(posedge clk_i) begin
    rr_q <= 64'(re_i) * 64'(re_i);
    ii_q <= 64'(im_i) * 64'(im_i);
    ri_q <= 64'(re_i) * 64'(im_i);
  end

  assign dr = 66'(rr_q) - 66'(ii_q) + HALF;
  assign di = (66'(ri_q) <<< 1) + HALF;

  always_ff @(posedge clk_i) begin
    re_o <= 32'(dr >>> 30);
    im_o <= 32'(di >>> 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      side_o <= '0;
    end else begin
      s1_q   <= side_i;
      side_o <= s1_q;
    end
  end
endmodule
`default_nettype wire

@@ sim/gabor_kernel_point_test.sv @@
// Self-checking testbench for gabor_kernel_point: APB register setup, request stream,
// and a scoreboard that predicts every kernel value in fixed point.
// Depends on gkp_pkg and the gabor_kernel_point RTL.
`timescale 1ns / 1ps
module gabor_kernel_point_test;

  localparam int LIMIT = 200000;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } kernel_pt_t;

  class kernel_board;
    longint cs, sn, gx, gy, freq, ph;
    kernel_pt_t pending[$];
    int errors;
    int checked;

    function void load_reset();
      cs = longint'(gkp_pkg::COS_RST); sn = longint'(gkp_pkg::SIN_RST);
      gx = longint'(gkp_pkg::GX_RST); gy = longint'(gkp_pkg::GY_RST);
      freq = longint'(gkp_pkg::FREQ_RST); ph = longint'(gkp_pkg::PHASE_RST);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        gkp_pkg::REG_COS:   cs = longint'($signed(d[15:0]));
        gkp_pkg::REG_SIN:   sn = longint'($signed(d[15:0]));
        gkp_pkg::REG_GX:    gx = longint'(d[23:0]);
        gkp_pkg::REG_GY:    gy = longint'(d[23:0]);
        gkp_pkg::REG_FREQ:  freq = longint'(d[19:0]);
        gkp_pkg::REG_PHASE: ph = longint'(d[15:0]);
        default: ;
      endcase
    endfunction

    function logic signed [15:0] kernel_at(logic signed [15:0] px, logic signed [15:0] py);
      longint x, y, xr, yr, re, im, rr, ii, ri, turns, v, t;
      logic [127:0] px2, py2, sum;
      logic [63:0] ax, ay, a;
      logic [15:0] p16;
      x = longint'(px);
      y = longint'(py);
      xr = (x * cs + y * sn + 64'sd8192) >>> 14;
      yr = (y * cs - x * sn + 64'sd8192) >>> 14;
      ax = (xr < 0) ? -xr : xr;
      ay = (yr < 0) ? -yr : yr;
      px2 = 128'(ax) * 128'(ax) * 128'(gx);
      py2 = 128'(ay) * 128'(ay) * 128'(gy);
      if (px2 > 128'hFFFF_FFFF_FFFF_FFFF) px2 = 128'hFFFF_FFFF_FFFF_FFFF;
      if (py2 > 128'hFFFF_FFFF_FFFF_FFFF) py2 = 128'hFFFF_FFFF_FFFF_FFFF;
      sum = px2 + py2;
      if (sum > 128'hFFFF_FFFF_FFFF_FFFF) sum = 128'hFFFF_FFFF_FFFF_FFFF;
      a = sum[63:0];
      if (65'(a) >= gkp_pkg::EXP_LIMIT_Q36) return 16'sd0;
      t = (freq * xr + 64'sd128) >>> 8;
      p16 = t[15:0] - ph[15:0];
      turns = longint'($signed(p16));
      re = (64'sd1 <<< 30) - longint'((a + (64'd1 << 21)) >> 22);
      im = (turns * longint'(gkp_pkg::TWO_PI_Q28) + (64'sd1 <<< 29)) >>> 30;
      for (int i = 0; i < gkp_pkg::ITERATIONS_DEF; i++) begin
        rr = re * re;
        ii = im * im;
        ri = re * im;
        re = (rr - ii + (64'sd1 <<< 29)) >>> 30;
        im = (2 * ri + (64'sd1 <<< 29)) >>> 30;
      end
      v = (re + 64'sd16384) >>> 15;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
    endfunction

    function void note_request(logic signed [15:0] px, logic signed [15:0] py, logic lp);
      kernel_pt_t e;
      e.value = kernel_at(px, py);
      e.last = lp;
      pending.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic signed [15:0] val, logic lo);
      kernel_pt_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %0d", val));
        return;
      end
      e = pending.pop_front();
      checked++;
      if (val !== e.value) report($sformatf("kernel_value %0d, want %0d", val, e.value));
      if (lo !== e.last) report($sformatf("last_out %b, want %b", lo, e.last));
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic signed [15:0] pos_x_i = 0, pos_y_i = 0;
  logic last_point_i = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  wire busy_o, kernel_valid_o, last_out_o, pready;
  wire signed [15:0] kernel_value_o;
  wire [31:0] prdata;

  kernel_board board;
  int cycles = 0;
  int sent = 0;
  int idle_pct = 0;

  gabor_kernel_point uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .pos_x_i(pos_x_i), .pos_y_i(pos_y_i), .last_point_i(last_point_i),
    .kernel_valid_o(kernel_valid_o), .kernel_value_o(kernel_value_o),
    .last_out_o(last_out_o), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("gabor_kernel_point_test: FAIL");
      $finish;
    end
    if (rst_ni) begin
      if (start_i && !busy_o) board.note_request(pos_x_i, pos_y_i, last_point_i);
      if (kernel_valid_o) board.check_result(kernel_value_o, last_out_o);
    end
  end

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (2 * gkp_pkg::ITERATIONS_DEF + 12) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] d);
    @(negedge clk_i);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = d;
    @(negedge clk_i);
    penable = 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.write_reg(idx, d);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic set_all(logic [15:0] c, logic [15:0] s, logic [23:0] gxv,
                         logic [23:0] gyv, logic [19:0] f, logic [15:0] p);
    drain();
    reg_write(gkp_pkg::REG_COS, {16'($urandom), c});
    reg_write(gkp_pkg::REG_SIN, {16'($urandom), s});
    reg_write(gkp_pkg::REG_GX, {8'($urandom), gxv});
    reg_write(gkp_pkg::REG_GY, {8'($urandom), gyv});
    reg_write(gkp_pkg::REG_FREQ, {12'($urandom), f});
    reg_write(gkp_pkg::REG_PHASE, {16'($urandom), p});
  endtask

  task automatic send(logic signed [15:0] x, logic signed [15:0] y, logic lp);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i = 0;
      @(negedge clk_i);
    end
    start_i = 1; pos_x_i = x; pos_y_i = y; last_point_i = lp;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic stop_requests();
    @(negedge clk_i);
    start_i = 0;
  endtask

  task automatic random_points(int n, int spread);
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (i < n / 3) idle_pct = 6;
      else if (i < 2 * n / 3) idle_pct = 52;
      else idle_pct = 0;
      if ($urandom_range(9, 0) < 7) begin
        x = $signed(16'($urandom_range(2 * spread, 0))) - 16'(spread);
        y = $signed(16'($urandom_range(2 * spread, 0))) - 16'(spread);
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      send(x, y, (i % 16) == 15);
    end
    stop_requests();
  endtask

  initial begin
    board = new();
    board.load_reset();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // reset values: origin, extremes, a few small points
    send(16'sd0, 16'sd0, 1'b0);
    send(16'sh7FFF, 16'sh7FFF, 1'b1);
    send(16'sh8000, 16'sh8000, 1'b0);
    send(16'sh8000, 16'sh7FFF, 1'b1);
    send(16'sd1024, 16'sd0, 1'b0);
    send(16'sd0, -16'sd1024, 1'b0);
    send(16'sd300, -16'sd200, 1'b1);
    stop_requests();

    // no envelope, zero phase: full scale at origin saturates
    set_all(16'sd16384, 16'd0, 24'd0, 24'd0, 20'd0, 16'd0);
    send(16'sd0, 16'sd0, 1'b1);
    send(16'sd4096, 16'sd4096, 1'b0);
    stop_requests();

    // strongest envelope: origin, a point next to it, and a far point that underflows
    set_all(-16'sd16384, 16'sd16384, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 16'hFFFF);
    send(16'sd0, 16'sd0, 1'b0);
    send(16'sd1, -16'sd1, 1'b1);
    send(16'sh7FFF, 16'sh8000, 1'b0);
    stop_requests();

    // out-of-range orientation and odd phase
    set_all(16'h8000, 16'h7FFF, 24'd10, 24'd3, 20'hFFFFF, 16'h8000);
    send(16'sd0, 16'sd0, 1'b0);
    send(16'sd3, -16'sd5, 1'b1);
    send(16'sd40, 16'sd17, 1'b0);
    stop_requests();

    // hold off until the pipe is empty
    drain();

    set_all(gkp_pkg::COS_RST, gkp_pkg::SIN_RST, gkp_pkg::GX_RST, gkp_pkg::GY_RST,
            gkp_pkg::FREQ_RST, gkp_pkg::PHASE_RST);
    random_points(100, 1024);
    for (int p = 0; p < 7; p++) begin
      set_all(16'($urandom_range(32768, 0) - 16384), 16'($urandom_range(32768, 0) - 16384),
              (p == 6) ? 24'($urandom) : 24'($urandom_range(300000, 0)),
              (p == 5) ? 24'($urandom) : 24'($urandom_range(300000, 0)),
              (p == 4) ? 20'($urandom) : 20'($urandom_range(40000, 0)),
              16'($urandom));
      random_points(100, (p % 2) ? 512 : 2048);
    end

    drain();
    $display("covered %0d requests, %0d results checked over %0d cycles",
             sent, board.checked, cycles);
    $display("register sets: reset, no envelope, underflow, extreme values, 7 random");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("gabor_kernel_point_test: PASS");
    end else begin
      $display("gabor_kernel_point_test: FAIL");
    end
    $finish;
  end
endmodule
